[rtl/cstr_pkg.sv]
`default_nettype none

package cstr_pkg;

    // Table geometry: 32-byte entries made of eight big-endian words.
    localparam int ENTRY_W         = 5;
    localparam int WORDS_PER_ENTRY = 8;
    localparam int SLOT_W          = 3;
    localparam int NUM_ENTRIES_DEFAULT = 32;

    // Word slots inside one entry.
    localparam logic [SLOT_W-1:0] SLOT_ADDR_HI = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_ADDR_LO = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_ARG_HI  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_ARG_LO  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_CORE_ID = 3'd5;

    // Access kinds and sizes.
    localparam logic       OP_READ   = 1'b0;
    localparam logic       OP_WRITE  = 1'b1;
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Size of the initial mapping handed to a released core.
    localparam int          MAP_BITS = 26;
    localparam logic [63:0] MAP_MASK = 64'((64'd1 << MAP_BITS) - 64'd1);

    // Configuration register file.
    localparam int         PADDR_W             = 3;
    localparam logic       REG_CORES_PRESENT   = 1'b0;
    localparam logic [5:0] CORES_PRESENT_RESET = 6'd32;

    typedef struct packed {
        logic        operation;
        logic [9:0]  byte_address;
        logic [1:0]  size_code;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        misaligned;
        logic        release_res;
        logic [4:0]  released_core;
        logic [25:0] start_pc;
        logic [63:0] mapping_base;
        logic [63:0] start_argument;
    } result_t;

    // Write-back of one access into the per-slot memories.
    typedef struct packed {
        logic [WORDS_PER_ENTRY-1:0]       we;
        logic [WORDS_PER_ENTRY-1:0][31:0] data;
        logic [ENTRY_W-1:0]               entry;
    } wb_t;

    // Right shift that brings the addressed bytes down to bit 0.
    function automatic logic [4:0] lane_shift(input logic [1:0] size, input logic [1:0] boff);
        logic [4:0] sh;
        case (size)
            SIZE_BYTE: sh = {2'd3 - boff, 3'b000};
            SIZE_HALF: sh = {2'd2 - boff, 3'b000};
            default:   sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [31:0] lane_mask(input logic [1:0] size, input logic [1:0] boff);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF << lane_shift(size, boff);
            SIZE_HALF: m = 32'h0000_FFFF << lane_shift(size, boff);
            SIZE_WORD: m = 32'hFFFF_FFFF;
            default:   m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    // Contents of a word that has not been written since reset.
    function automatic logic [31:0] reset_word(input logic [SLOT_W-1:0] slot,
                                               input logic [ENTRY_W-1:0] entry);
        logic [31:0] w;
        case (slot)
            SLOT_ADDR_LO: w = 32'd1;
            SLOT_ARG_LO:  w = 32'(entry);
            SLOT_CORE_ID: w = 32'(entry);
            default:      w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/cstr_cfg.sv]
`default_nettype none

module cstr_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cstr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [5:0]                         cores_present
);

    logic [5:0] cores_present_reg;
    logic       reg_index;

    assign reg_index     = paddr[2];
    assign pready        = 1'b1;
    assign cores_present = cores_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cores_present_reg <= cstr_pkg::CORES_PRESENT_RESET;
        end
        else if (psel && penable && pwrite && reg_index == cstr_pkg::REG_CORES_PRESENT)
        begin
            cores_present_reg <= pwdata[5:0];
        end
    end

    always_comb
    begin
        if (reg_index == cstr_pkg::REG_CORES_PRESENT)
        begin
            prdata = 32'(cores_present_reg);
        end
        else
        begin
            prdata = 32'd0;
        end
    end

endmodule

`default_nettype wire

[rtl/cstr_slot_mem.sv]
`default_nettype none

module cstr_slot_mem #(
    parameter int NUM_ENTRIES = cstr_pkg::NUM_ENTRIES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            re,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]  raddr,
    input  wire logic                            we,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]  waddr,
    input  wire logic [31:0]                     wdata,
    output logic [31:0]                          rdata,
    output logic                                 rvalid
);

    logic [31:0]            mem_reg [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [31:0]            rdata_reg;
    logic                   rvalid_reg;
    logic                   hit;

    // A read of the word being written this edge sees the new data.
    assign hit    = we && (waddr == raddr);
    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= hit ? wdata : mem_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= hit || valid_reg[raddr];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cstr_access.sv]
`default_nettype none

module cstr_access #(
    parameter int NUM_ENTRIES = cstr_pkg::NUM_ENTRIES_DEFAULT
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            valid,
    input  wire cstr_pkg::item_t                                 item,
    input  wire logic [cstr_pkg::WORDS_PER_ENTRY-1:0][31:0]      rdata,
    input  wire logic [cstr_pkg::WORDS_PER_ENTRY-1:0]            rvalid,
    input  wire logic [5:0]                                      cores_present,
    output cstr_pkg::wb_t                                        wb,
    output cstr_pkg::result_t                                    result,
    output logic                                                 result_valid
);

    localparam int WORDS = cstr_pkg::WORDS_PER_ENTRY;

    logic [cstr_pkg::ENTRY_W-1:0]  entry;
    logic [cstr_pkg::SLOT_W-1:0]   widx;
    logic [1:0]                    boff;
    logic [4:0]                    shift;
    logic [31:0]                   fmask;
    logic                          size_ok;
    logic                          aligned;
    logic                          in_table;
    logic                          wr_ok;
    logic                          rel;
    logic [WORDS-1:0][31:0]        word;
    logic [WORDS-1:0][31:0]        word_new;
    logic [31:0]                   merged;
    logic [63:0]                   raddr;
    logic [63:0]                   arg;
    cstr_pkg::result_t             res_next;
    cstr_pkg::result_t             result_reg;
    logic                          result_valid_reg;

    always_comb
    begin
        entry = item.byte_address[9:5];
        widx  = item.byte_address[4:2];
        boff  = item.byte_address[1:0];
        shift = cstr_pkg::lane_shift(item.size_code, boff);
        fmask = cstr_pkg::lane_mask(item.size_code, boff);

        size_ok = item.size_code inside {cstr_pkg::SIZE_BYTE, cstr_pkg::SIZE_HALF,
                                         cstr_pkg::SIZE_WORD};
        case (item.size_code)
            cstr_pkg::SIZE_HALF: aligned = !item.byte_address[0];
            cstr_pkg::SIZE_WORD: aligned = (item.byte_address[1:0] == 2'b00);
            default:             aligned = 1'b1;
        endcase
        in_table = 32'(entry) < 32'(NUM_ENTRIES);

        // Words never written since reset read as their reset contents.
        for (int s = 0; s < WORDS; s++)
        begin
            word[s] = rvalid[s] ? rdata[s] : cstr_pkg::reset_word(3'(s), entry);
        end

        merged = (word[widx] & ~fmask) | ((item.write_data << shift) & fmask);

        // Core 0 and cores that are not present are never written.
        wr_ok = valid && (item.operation == cstr_pkg::OP_WRITE) && size_ok && aligned
                && in_table && (entry != '0) && ({1'b0, entry} < cores_present);

        for (int s = 0; s < WORDS; s++)
        begin
            word_new[s] = (wr_ok && widx == 3'(s)) ? merged : word[s];
        end

        raddr = {word_new[cstr_pkg::SLOT_ADDR_HI], word_new[cstr_pkg::SLOT_ADDR_LO]};
        arg   = {word_new[cstr_pkg::SLOT_ARG_HI], word_new[cstr_pkg::SLOT_ARG_LO]};
        rel   = wr_ok && !raddr[0];

        res_next = '0;
        if (size_ok && !aligned)
        begin
            res_next.misaligned = 1'b1;
        end
        else if (size_ok && in_table && item.operation == cstr_pkg::OP_READ)
        begin
            res_next.read_data = (word[widx] & fmask) >> shift;
        end
        if (rel)
        begin
            res_next.release_res    = 1'b1;
            res_next.released_core  = entry;
            res_next.start_pc       = 26'(raddr & cstr_pkg::MAP_MASK);
            res_next.mapping_base   = raddr & ~cstr_pkg::MAP_MASK;
            res_next.start_argument = arg;
        end

        // A release also stamps the core id word, which wins over the data.
        wb.entry = entry;
        for (int s = 0; s < WORDS; s++)
        begin
            if (rel && 3'(s) == cstr_pkg::SLOT_CORE_ID)
            begin
                wb.we[s]   = 1'b1;
                wb.data[s] = 32'(entry);
            end
            else
            begin
                wb.we[s]   = wr_ok && (widx == 3'(s));
                wb.data[s] = merged;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= valid;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

[rtl/cpu_spin_table_release_core.sv]
// Spin table for releasing secondary cores.
//
// The table holds one 32-byte big-endian entry per core: release address,
// start argument, a reserved word, the core id and a reserved doubleword.
// Software reads and writes it with 1-, 2- or 4-byte accesses on the
// command channel. A beat is taken at a rising edge where start is high and
// busy is low; busy is always low, so a new access may be issued in every
// cycle. Each access produces exactly one result beat, shown on result for
// one cycle with result_valid high after the input and result registers.
// The receiver cannot stall the result, and nothing in the block waits on it.
// The rate is one access per cycle, set by the single read port and single
// write port of each of the eight word-slot memories, which are read at the
// accepting edge and written back at the next.
// A write that leaves a present secondary core's release address even
// releases that core: the result carries the start pc, the mapping base and
// the argument, and the core id word is stamped with the entry index.
// The APB port holds cores_present at byte address 0. Reset restores it to
// 32 and marks every table word unwritten, so the table reads its reset
// contents at once with no clearing pass.
`default_nettype none

module cpu_spin_table_release_core #(
    parameter int NUM_ENTRIES = cstr_pkg::NUM_ENTRIES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cstr_pkg::item_t               request,
    output cstr_pkg::result_t                  result,
    output logic                               result_valid,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cstr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int WORDS = cstr_pkg::WORDS_PER_ENTRY;
    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int EXT_W = (IDX_W > cstr_pkg::ENTRY_W) ? IDX_W : cstr_pkg::ENTRY_W;

    logic                    accept;
    logic                    s1_valid_reg;
    cstr_pkg::item_t         s1_item_reg;
    logic [5:0]              cores_present;
    logic [EXT_W-1:0]        rd_entry_ext;
    logic [EXT_W-1:0]        wr_entry_ext;
    logic [WORDS-1:0][31:0]  rdata;
    logic [WORDS-1:0]        rvalid;
    cstr_pkg::wb_t           wb;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register: the access waits here while its entry is read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    cstr_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cores_present (cores_present)
    );

    // Entries past the table index a don't-care word; the access logic
    // discards whatever comes back for them.
    assign rd_entry_ext = EXT_W'(request.byte_address[9:5]);
    assign wr_entry_ext = EXT_W'(wb.entry);

    // One memory per word slot, so a whole entry is read at once.
    for (genvar s = 0; s < WORDS; s++)
    begin : g_slot
        cstr_slot_mem #(
            .NUM_ENTRIES (NUM_ENTRIES)
        ) u_mem (
            .clk    (clk),
            .rst_n  (rst_n),
            .re     (accept),
            .raddr  (rd_entry_ext[IDX_W-1:0]),
            .we     (wb.we[s]),
            .waddr  (wr_entry_ext[IDX_W-1:0]),
            .wdata  (wb.data[s]),
            .rdata  (rdata[s]),
            .rvalid (rvalid[s])
        );
    end

    cstr_access #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_access (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (s1_valid_reg),
        .item          (s1_item_reg),
        .rdata         (rdata),
        .rvalid        (rvalid),
        .cores_present (cores_present),
        .wb            (wb),
        .result        (result),
        .result_valid  (result_valid)
    );

    // Every access in the input register yields a result beat next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> result_valid)
        else $error("access in flight produced no result beat");

    // A release only ever names a present secondary core.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.release_res |->
            result.released_core != '0 && {1'b0, result.released_core} < cores_present)
        else $error("release of core 0 or of a core that is not present");

    // A released core starts at an even address.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.release_res |-> !result.start_pc[0])
        else $error("release reported with an odd start pc");

    // A misaligned access neither returns data nor releases a core.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.misaligned |->
            result.read_data == '0 && !result.release_res)
        else $error("misaligned access had an effect");

    // The write-back of a release stamps the core id of the released entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.release_res |->
            $past(wb.we[cstr_pkg::SLOT_CORE_ID])
            && $past(wb.entry) == result.released_core)
        else $error("release without core id write-back");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

// Testbench for the spin table core.
//
// The bench keeps its own copy of the spin table and of cores_present.
// Every access is predicted at the edge where the block takes it, and the
// expected result beat is queued. A checker process pops one expectation per
// result beat and compares every field of the result. The configuration
// register is changed only when the command channel has drained.
module tb;

    // The size code that no access width maps to; such accesses do nothing.
    localparam logic [1:0] SIZE_NONE = 2'd3;
    localparam int TABLE_WORDS = cstr_pkg::NUM_ENTRIES_DEFAULT * cstr_pkg::WORDS_PER_ENTRY;
    // Approximate number of accesses for the whole run.
    localparam int TOTAL_ITEMS = 550;
    // The last stretch of accesses runs with no random idle bursts.
    localparam int CALM_ITEMS = 100;
    // Byte offsets of the fields inside one 32-byte entry.
    localparam int OFFS_ADDR_HI = 0;
    localparam int OFFS_ADDR_LO = 4;
    localparam int OFFS_ARG_HI  = 8;
    localparam int OFFS_ARG_LO  = 12;
    localparam int OFFS_RSVD    = 16;
    localparam int OFFS_CORE_ID = 20;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cstr_pkg::item_t   request;
    cstr_pkg::result_t result;
    logic              result_valid;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [cstr_pkg::PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the table and of the core count.
    logic [31:0] spin_mem [0:TABLE_WORDS-1];
    logic [5:0]  cores_cfg;

    // One expected result beat per accepted access, oldest first.
    cstr_pkg::result_t expected_results[$];
    int                error_count = 0;
    int                items_sent = 0;
    // When set, the sender inserts random idle bursts between beats.
    bit                gaps_on = 1'b1;

    cpu_spin_table_release_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Puts the shadow table into its reset state: every release address is
    // one (so no core is released), argument and core id hold the index.
    function automatic void reset_shadow();
        int eb;
        for (int i = 0; i < TABLE_WORDS; i++)
        begin
            spin_mem[i] = 32'd0;
        end
        for (int e = 0; e < cstr_pkg::NUM_ENTRIES_DEFAULT; e++)
        begin
            eb = e * cstr_pkg::WORDS_PER_ENTRY;
            spin_mem[eb + int'(cstr_pkg::SLOT_ADDR_LO)] = 32'd1;
            spin_mem[eb + int'(cstr_pkg::SLOT_ARG_LO)]  = 32'(e);
            spin_mem[eb + int'(cstr_pkg::SLOT_CORE_ID)] = 32'(e);
        end
        cores_cfg = cstr_pkg::CORES_PRESENT_RESET;
    endfunction

    // Works out the result of one access and applies its effect on the
    // shadow table. The order of the checks matters: an unused size code
    // beats misalignment, and misalignment beats everything else.
    function automatic cstr_pkg::result_t predict_access(input cstr_pkg::item_t it);
        cstr_pkg::result_t r;
        int                nbytes;
        int                entry;
        int                widx;
        int                boff;
        int                shift;
        int                eb;
        logic [31:0]       fmask;
        logic [63:0]       rel_addr;
        r = '0;
        if (it.size_code == SIZE_NONE)
        begin
            return r;
        end
        nbytes = 1 << it.size_code;
        if ((it.byte_address & 10'(nbytes - 1)) != 10'd0)
        begin
            r.misaligned = 1'b1;
            return r;
        end
        entry = int'(it.byte_address) >> 5;
        widx  = entry * cstr_pkg::WORDS_PER_ENTRY + ((int'(it.byte_address) & 31) >> 2);
        boff  = int'(it.byte_address) & 3;
        // The table is big-endian: byte offset 0 is the top byte of a word.
        shift = (4 - nbytes - boff) * 8;
        fmask = (nbytes == 4) ? 32'hFFFF_FFFF
                              : (((32'd1 << (nbytes * 8)) - 32'd1) << shift);
        if (it.operation == cstr_pkg::OP_READ)
        begin
            r.read_data = (spin_mem[widx] & fmask) >> shift;
            return r;
        end
        // Core 0 is the boot core and missing cores have no entry to write.
        if (entry == 0 || entry >= int'(cores_cfg))
        begin
            return r;
        end
        spin_mem[widx] = (spin_mem[widx] & ~fmask) | ((it.write_data << shift) & fmask);
        eb = entry * cstr_pkg::WORDS_PER_ENTRY;
        rel_addr = {spin_mem[eb + int'(cstr_pkg::SLOT_ADDR_HI)],
                    spin_mem[eb + int'(cstr_pkg::SLOT_ADDR_LO)]};
        // Any accepted write that leaves the release address even releases
        // the core, even if it was released before.
        if (!rel_addr[0])
        begin
            spin_mem[eb + int'(cstr_pkg::SLOT_CORE_ID)] = 32'(entry);
            r.release_res    = 1'b1;
            r.released_core  = 5'(entry);
            r.start_pc       = rel_addr[cstr_pkg::MAP_BITS-1:0];
            r.mapping_base   = rel_addr & ~cstr_pkg::MAP_MASK;
            r.start_argument = {spin_mem[eb + int'(cstr_pkg::SLOT_ARG_HI)],
                                spin_mem[eb + int'(cstr_pkg::SLOT_ARG_LO)]};
        end
        return r;
    endfunction

    function automatic cstr_pkg::item_t make_access(input logic op, input int addr,
                                                    input logic [1:0] size,
                                                    input logic [31:0] data);
        cstr_pkg::item_t it;
        it.operation    = op;
        it.byte_address = 10'(addr);
        it.size_code    = size;
        it.write_data   = data;
        return it;
    endfunction

    // Mostly aligned accesses of the three real sizes, with a share of
    // misaligned ones and of the unused size code mixed in.
    function automatic cstr_pkg::item_t random_access();
        cstr_pkg::item_t it;
        int              nbytes;
        it.operation    = logic'($urandom_range(0, 1));
        it.size_code    = ($urandom_range(0, 15) == 0) ? SIZE_NONE : 2'($urandom_range(0, 2));
        it.byte_address = 10'($urandom);
        it.write_data   = $urandom;
        if (it.size_code != SIZE_NONE && $urandom_range(0, 7) != 0)
        begin
            nbytes = 1 << it.size_code;
            it.byte_address = it.byte_address & ~10'(nbytes - 1);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Drops start and holds the channel idle for a burst of random length.
    // The request bus carries junk meanwhile, which the block must ignore.
    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 6);
        @(negedge clk);
        start   <= 1'b0;
        request <= random_access();
        repeat (n) @(posedge clk);
    endtask

    // Sends one access beat. Start stays high after acceptance; whatever the
    // caller does next touches start at the following falling edge, before
    // the block can see it again.
    task automatic send_access(input cstr_pkg::item_t it);
        @(negedge clk);
        start   <= 1'b1;
        request <= it;
        do @(posedge clk); while (busy);
        expected_results.push_back(predict_access(it));
        items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            idle_burst();
        end
    endtask

    // Takes the channel down and waits until every result has come back.
    // Every access yields exactly one result, so nothing is left in flight
    // once the queue is empty.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One APB transfer on the cores_present register. A write updates the
    // shadow at the completing edge; a read is checked against the shadow.
    task automatic apb_cores(input logic do_write, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= do_write;
        paddr   <= cstr_pkg::PADDR_W'(int'(cstr_pkg::REG_CORES_PRESENT) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (do_write)
        begin
            cores_cfg = value[5:0];
        end
        else if (prdata !== {26'd0, cores_cfg})
        begin
            report_mismatch("cores_present readback", 64'(prdata), 64'(cores_cfg));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Changes the core count between phases, then reads it back.
    task automatic set_cores(input int count);
        wait_idle();
        apb_cores(1'b1, 32'(count));
        apb_cores(1'b0, 32'd0);
    endtask

    // Write and read of one table location, with the access kind named.
    task automatic send_write(input int addr, input logic [1:0] size, input logic [31:0] data);
        send_access(make_access(cstr_pkg::OP_WRITE, addr, size, data));
    endtask

    task automatic send_read(input int addr, input logic [1:0] size, input logic [31:0] data);
        send_access(make_access(cstr_pkg::OP_READ, addr, size, data));
    endtask

    // A well-formed release: software fills in the argument and the high
    // half of the release address, then writes the low half last. The low
    // half is written as a word, a half or a byte, and is usually even.
    // The core id is read back afterwards to see the stamp.
    task automatic release_sequence(input int entry);
        int          base;
        logic [31:0] lo;
        base = entry * 32;
        lo = $urandom;
        lo[0] = ($urandom_range(0, 4) == 0);
        send_write(base + OFFS_ADDR_HI, cstr_pkg::SIZE_WORD,
                   ($urandom_range(0, 1) != 0) ? $urandom : 32'd0);
        if ($urandom_range(0, 1) != 0)
        begin
            send_write(base + OFFS_ARG_HI, cstr_pkg::SIZE_WORD, $urandom);
            send_write(base + OFFS_ARG_LO, cstr_pkg::SIZE_WORD, $urandom);
        end
        else
        begin
            send_write(base + OFFS_ARG_LO + 2, cstr_pkg::SIZE_HALF, $urandom);
        end
        case ($urandom_range(0, 2))
            0: send_write(base + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, lo);
            1: send_write(base + OFFS_ADDR_LO + 2, cstr_pkg::SIZE_HALF, lo);
            default: send_write(base + OFFS_ADDR_LO + 3, cstr_pkg::SIZE_BYTE, lo);
        endcase
        send_read(base + OFFS_CORE_ID, cstr_pkg::SIZE_WORD, $urandom);
    endtask

    // Picks a writable entry, or entry 1 when only the boot core is present.
    function automatic int writable_entry();
        return (cores_cfg > 6'd1) ? $urandom_range(1, int'(cores_cfg) - 1) : 1;
    endfunction

    // Reset contents, edges of the address range, every size, the unused
    // size code, misaligned accesses, writes to the boot core, a release
    // that is repeated, and a release of entry 31 whose address then goes odd.
    task automatic test_directed();
        send_read(OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(1023, cstr_pkg::SIZE_BYTE, 32'hFFFF_FFFF);
        send_read(31 * 32 + OFFS_CORE_ID, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(3 * 32 + OFFS_ARG_LO + 2, cstr_pkg::SIZE_HALF, 32'd0);
        send_read(0, cstr_pkg::SIZE_BYTE, 32'd0);
        // The boot core's entry is read-only from the bus.
        send_write(OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        // Unused size code, on a read and on a write that would release.
        send_read(OFFS_ADDR_LO, SIZE_NONE, 32'd0);
        send_write(32 + OFFS_ADDR_LO, SIZE_NONE, 32'd0);
        // Misaligned halves and words are flagged and have no effect.
        send_read(1, cstr_pkg::SIZE_HALF, 32'd0);
        send_write(32 + 6, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(1022, cstr_pkg::SIZE_WORD, 32'd0);
        // Build a release of core 1; the low address word stays odd for now.
        send_write(32 + OFFS_ADDR_HI, cstr_pkg::SIZE_WORD, 32'hFFFF_FFFF);
        send_write(32 + OFFS_ARG_HI, cstr_pkg::SIZE_WORD, 32'h89AB_CDEF);
        send_write(32 + OFFS_ARG_LO, cstr_pkg::SIZE_WORD, 32'h0123_4567);
        send_write(32 + OFFS_CORE_ID, cstr_pkg::SIZE_WORD, 32'd0);
        send_write(32 + OFFS_RSVD, cstr_pkg::SIZE_WORD, 32'hA5A5_5A5A);
        // A byte write makes the address even and releases the core.
        send_write(32 + OFFS_ADDR_LO + 3, cstr_pkg::SIZE_BYTE, 32'hFFFF_FFFE);
        send_read(32 + OFFS_CORE_ID, cstr_pkg::SIZE_WORD, 32'd0);
        // A second write that keeps it even releases it again.
        send_write(32 + OFFS_ADDR_LO + 2, cstr_pkg::SIZE_HALF, 32'h0000_ABCE);
        send_write(31 * 32 + 28, cstr_pkg::SIZE_WORD, 32'hFFFF_FFFF);
        send_write(31 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        send_write(31 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'hFFFF_FFFF);
        send_read(32 + OFFS_ADDR_HI, cstr_pkg::SIZE_WORD, 32'd0);
    endtask

    // Writes to entries on both sides of the configured core count.
    task automatic test_core_limit();
        set_cores(1);
        send_write(32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'h0000_1000);
        send_write(31 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        set_cores(32);
        release_sequence(31);
        release_sequence(1);
        set_cores(2);
        send_write(2 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        release_sequence(1);
        set_cores(17);
        release_sequence(16);
        send_write(17 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
        send_read(17 * 32 + OFFS_ADDR_LO, cstr_pkg::SIZE_WORD, 32'd0);
    endtask

    // Directed releases over a spread of entries with random content.
    task automatic test_release_sequences();
        set_cores(32);
        for (int i = 0; i < 12; i++)
        begin
            release_sequence(writable_entry());
        end
    endtask

    // Random traffic in phases, each with its own core count. Most of it is
    // well-formed release sequences; the rest is single random accesses.
    task automatic test_random_traffic();
        int phase_items;
        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: set_cores(1);
                1: set_cores(32);
                default: set_cores($urandom_range(1, 32));
            endcase
            phase_items = items_sent + $urandom_range(40, 90);
            while (items_sent < phase_items && items_sent < TOTAL_ITEMS)
            begin
                // The tail of the run has no random idle bursts between beats.
                gaps_on = (items_sent < TOTAL_ITEMS - CALM_ITEMS);
                if ($urandom_range(0, 9) < 4)
                begin
                    release_sequence(writable_entry());
                end
                else
                begin
                    send_access(random_access());
                end
            end
        end
    endtask

    // Every result beat must match the oldest expectation, field by field.
    always @(posedge clk)
    begin : check_results
        cstr_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result beat with nothing expected", 64'(result.read_data), 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.read_data !== want.read_data)
                begin
                    report_mismatch("read_data", 64'(result.read_data), 64'(want.read_data));
                end
                if (result.misaligned !== want.misaligned)
                begin
                    report_mismatch("misaligned", 64'(result.misaligned), 64'(want.misaligned));
                end
                if (result.release_res !== want.release_res)
                begin
                    report_mismatch("release_res", 64'(result.release_res),
                                    64'(want.release_res));
                end
                if (result.released_core !== want.released_core)
                begin
                    report_mismatch("released_core", 64'(result.released_core),
                                    64'(want.released_core));
                end
                if (result.start_pc !== want.start_pc)
                begin
                    report_mismatch("start_pc", 64'(result.start_pc), 64'(want.start_pc));
                end
                if (result.mapping_base !== want.mapping_base)
                begin
                    report_mismatch("mapping_base", result.mapping_base, want.mapping_base);
                end
                if (result.start_argument !== want.start_argument)
                begin
                    report_mismatch("start_argument", result.start_argument,
                                    want.start_argument);
                end
            end
        end
    end

    // Main sequence: reset once, run the tests in turn, drain, then judge.
    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = 32'd0;
        reset_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The core count must read back as its reset value.
        apb_cores(1'b0, 32'd0);
        test_directed();
        test_core_limit();
        test_release_sequences();
        test_random_traffic();

        wait_idle();
        // Waiting on after the drain catches any stray result beat.
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog. Ends the run as failed if it does not finish in time.
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
